/* design/lcs_pkg.sv */
package lcs_pkg;

    // Operand width of every value field
    localparam int WIDTH = 31;
    localparam int CNT_W = $clog2(WIDTH + 1);

    // Result status codes
    localparam logic [1:0] ST_SOLVED     = 2'd0;
    localparam logic [1:0] ST_NO_INVERSE = 2'd1;
    localparam logic [1:0] ST_ZERO_MOD   = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_DIV,
        S_MUL,
        S_UPD,
        S_FMUL,
        S_OUT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic mul_q_start;
        logic mul_b_start;
        logic mul_step;
        logic update;
        logic finish;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic m_zero;
        logic r_cur_zero;
        logic gcd_one;
        logic div_last;
        logic mul_done;
    } t_dp_stat;

endpackage

/* design/lcs_div.sv */
module lcs_div
    import lcs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_step,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic [WIDTH-1:0] o_quotient,
    output logic [WIDTH-1:0] o_remainder,
    output logic             o_last
);

    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [CNT_W-1:0] r_cnt;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_quo[WIDTH-1]};
        diff  = trial - {1'b0, i_divisor};
        fits  = (trial >= {1'b0, i_divisor});
        n_rem = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
        n_quo = {r_quo[WIDTH-2:0], fits};
    end

    // Hold the partial remainder and the quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (i_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // Count the steps of one division
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= '0;
        end else if (i_step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // Flag the quotient and remainder final once all WIDTH steps are done
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_last      = (r_cnt == CNT_W'(WIDTH));

endmodule

/* design/lcs_mulmod.sv */
module lcs_mulmod
    import lcs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_load,
    input  logic             i_step,
    input  logic [WIDTH-1:0] i_mult,
    input  logic [WIDTH-1:0] i_base,
    input  logic [WIDTH-1:0] i_modulus,
    output logic [WIDTH-1:0] o_product,
    output logic             o_done
);

    logic [WIDTH-1:0] r_mult;
    logic [WIDTH-1:0] r_acc, n_acc;
    logic [WIDTH-1:0] r_base, n_base;
    logic [WIDTH:0]   acc_sum;
    logic [WIDTH:0]   acc_red;
    logic [WIDTH:0]   dbl_sum;
    logic [WIDTH:0]   dbl_red;

    // Add the base when the low multiplier bit is set; double the base, both mod m
    always_comb begin
        acc_sum = {1'b0, r_acc} + {1'b0, r_base};
        acc_red = acc_sum - {1'b0, i_modulus};
        dbl_sum = {r_base, 1'b0};
        dbl_red = dbl_sum - {1'b0, i_modulus};
        n_acc   = r_acc;
        if (r_mult[0]) begin
            n_acc = (acc_sum >= {1'b0, i_modulus}) ? acc_red[WIDTH-1:0] : acc_sum[WIDTH-1:0];
        end
        n_base = (dbl_sum >= {1'b0, i_modulus}) ? dbl_red[WIDTH-1:0] : dbl_sum[WIDTH-1:0];
    end

    // Advance one multiplier bit per step, LSB first
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mult <= i_mult;
            r_acc  <= '0;
            r_base <= i_base;
        end else if (i_step) begin
            r_mult <= {1'b0, r_mult[WIDTH-1:1]};
            r_acc  <= n_acc;
            r_base <= n_base;
        end
    end

    assign o_product = r_acc;
    assign o_done    = (r_mult == '0);

endmodule

/* design/lcs_dp.sv */
module lcs_dp
    import lcs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  logic [WIDTH-1:0] i_coefficient,
    input  logic [WIDTH-1:0] i_rhs_value,
    input  logic [WIDTH-1:0] i_modulus,
    output t_dp_stat         o_stat,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [WIDTH-1:0] o_solution,
    output logic [WIDTH-1:0] o_inverse,
    output logic [WIDTH-1:0] o_common_divisor
);

    logic [WIDTH-1:0] r_prev;
    logic [WIDTH-1:0] r_cur;
    logic [WIDTH-1:0] r_s_prev;
    logic [WIDTH-1:0] r_s_cur;
    logic [WIDTH-1:0] n_s_cur;
    logic [WIDTH-1:0] r_b;
    logic [WIDTH-1:0] r_m;
    logic             r_done;
    logic [1:0]       r_status;
    logic [WIDTH-1:0] r_solution;
    logic [WIDTH-1:0] r_inverse;
    logic [WIDTH-1:0] r_gcd;

    logic [WIDTH-1:0] quotient;
    logic [WIDTH-1:0] remainder;
    logic             div_last;
    logic [WIDTH-1:0] product;
    logic             mul_done;
    logic [WIDTH-1:0] mul_mult;
    logic [WIDTH-1:0] mul_base;
    logic [WIDTH:0]   s_diff;
    logic [WIDTH:0]   s_wrap;

    lcs_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_step      (i_cmd.div_step),
        .i_dividend  (r_prev),
        .i_divisor   (r_cur),
        .o_quotient  (quotient),
        .o_remainder (remainder),
        .o_last      (div_last)
    );

    // Share the modular multiplier between q*s and the final inverse*b
    assign mul_mult = i_cmd.mul_b_start ? r_b : quotient;
    assign mul_base = i_cmd.mul_b_start ? r_s_prev : r_s_cur;

    lcs_mulmod u_mul (
        .i_clk     (i_clk),
        .i_load    (i_cmd.mul_q_start | i_cmd.mul_b_start),
        .i_step    (i_cmd.mul_step),
        .i_mult    (mul_mult),
        .i_base    (mul_base),
        .i_modulus (r_m),
        .o_product (product),
        .o_done    (mul_done)
    );

    // Next Bezout coefficient: s_prev - q*s_cur mod m
    always_comb begin
        s_diff  = {1'b0, r_s_prev} - {1'b0, product};
        s_wrap  = s_diff + {1'b0, r_m};
        n_s_cur = s_diff[WIDTH] ? s_wrap[WIDTH-1:0] : s_diff[WIDTH-1:0];
    end

    // Capture operands, then advance the Euclidean pair
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_prev   <= i_coefficient;
            r_cur    <= i_modulus;
            r_s_prev <= (i_modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
            r_s_cur  <= '0;
            r_b      <= i_rhs_value;
            r_m      <= i_modulus;
        end else if (i_cmd.update) begin
            r_prev   <= r_cur;
            r_cur    <= remainder;
            r_s_prev <= r_s_cur;
            r_s_cur  <= n_s_cur;
        end
    end

    // Latch the result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_gcd <= r_prev;
            if (r_m == '0) begin
                r_status   <= ST_ZERO_MOD;
                r_solution <= '0;
                r_inverse  <= '0;
            end else if (r_prev == WIDTH'(1)) begin
                r_status   <= ST_SOLVED;
                r_solution <= product;
                r_inverse  <= r_s_prev;
            end else begin
                r_status   <= ST_NO_INVERSE;
                r_solution <= '0;
                r_inverse  <= '0;
            end
        end
    end

    // Pulse the result strobe for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
        end
    end

    assign o_stat.m_zero     = (r_m == '0);
    assign o_stat.r_cur_zero = (r_cur == '0);
    assign o_stat.gcd_one    = (r_prev == WIDTH'(1));
    assign o_stat.div_last   = div_last;
    assign o_stat.mul_done   = mul_done;

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_solution       = r_solution;
    assign o_inverse        = r_inverse;
    assign o_common_divisor = r_gcd;

endmodule

/* design/lcs_ctrl.sv */
module lcs_ctrl
    import lcs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    t_state r_state, n_state;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_TEST;
            end
            S_TEST: begin
                priority if (i_stat.m_zero)      n_state = S_OUT;
                else if (!i_stat.r_cur_zero)     n_state = S_DIV;
                else if (i_stat.gcd_one)         n_state = S_FMUL;
                else                             n_state = S_OUT;
            end
            S_DIV: begin
                if (i_stat.div_last) n_state = S_MUL;
            end
            S_MUL: begin
                if (i_stat.mul_done) n_state = S_UPD;
            end
            S_UPD:  n_state = S_TEST;
            S_FMUL: begin
                if (i_stat.mul_done) n_state = S_OUT;
            end
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: o_cmd.load = i_start;
            S_TEST: begin
                if (!i_stat.m_zero) begin
                    if (!i_stat.r_cur_zero) begin
                        o_cmd.div_start = 1'b1;
                    end else if (i_stat.gcd_one) begin
                        o_cmd.mul_b_start = 1'b1;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step    = !i_stat.div_last;
                o_cmd.mul_q_start = i_stat.div_last;
            end
            S_MUL:  o_cmd.mul_step = !i_stat.mul_done;
            S_UPD:  o_cmd.update = 1'b1;
            S_FMUL: o_cmd.mul_step = !i_stat.mul_done;
            S_OUT:  o_cmd.finish = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* design/linear_congruence_solver_core.sv */
// Solves a*x = b (mod m) for one transfer at a time with the extended Euclidean
// algorithm. A transfer is taken when start is high and busy is low; busy stays
// high until the result is out. Each Euclidean step passes through a test state,
// a WIDTH-step restoring divider and a hand-over of the quotient, a shift-add
// modular multiplier that steps through the significant quotient bits and then
// signals done, and an update state. A solved item adds one multiplier pass over
// the bits of b. Most of the run time is spent in the divider. The result appears
// on o_status, o_solution, o_inverse and o_common_divisor for exactly one cycle,
// marked by o_done, and must be taken then: the receiver cannot stall the block.
// A new item may be started in the cycle o_done is high.
module linear_congruence_solver_core
    import lcs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [WIDTH-1:0] i_coefficient,
    input  logic [WIDTH-1:0] i_rhs_value,
    input  logic [WIDTH-1:0] i_modulus,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [WIDTH-1:0] o_solution,
    output logic [WIDTH-1:0] o_inverse,
    output logic [WIDTH-1:0] o_common_divisor
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    lcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    lcs_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_coefficient    (i_coefficient),
        .i_rhs_value      (i_rhs_value),
        .i_modulus        (i_modulus),
        .o_stat           (stat),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_solution       (o_solution),
        .o_inverse        (o_inverse),
        .o_common_divisor (o_common_divisor)
    );

endmodule

/* dv/tb_linear_congruence_solver_core.sv */
module tb_linear_congruence_solver_core
    import lcs_pkg::*;
;

    localparam logic [WIDTH-1:0] MAX_VAL   = {WIDTH{1'b1}};
    localparam int               N_RANDOM  = 1250;
    localparam int               STALL_MAX = 12000;
    localparam int               DRAIN_CYC = 200;

    typedef struct {
        logic [WIDTH-1:0] coefficient;
        logic [WIDTH-1:0] rhs_value;
        logic [WIDTH-1:0] modulus;
    } t_congruence;

    typedef struct {
        logic [1:0]       status;
        logic [WIDTH-1:0] solution;
        logic [WIDTH-1:0] inverse;
        logic [WIDTH-1:0] common_divisor;
    } t_solution;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [WIDTH-1:0] i_coefficient = '0;
    logic [WIDTH-1:0] i_rhs_value = '0;
    logic [WIDTH-1:0] i_modulus = '0;
    logic             o_done;
    logic [1:0]       o_status;
    logic [WIDTH-1:0] o_solution;
    logic [WIDTH-1:0] o_inverse;
    logic [WIDTH-1:0] o_common_divisor;

    t_congruence congruence_queue[$];
    t_solution   pending_solutions[$];
    t_congruence next_congruence;

    int mismatch_count = 0;
    int n_offered      = 0;
    int n_solved       = 0;
    int n_no_inverse   = 0;
    int n_zero_mod     = 0;
    int n_checked      = 0;
    int stall_cycles   = 0;

    linear_congruence_solver_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_coefficient    (i_coefficient),
        .i_rhs_value      (i_rhs_value),
        .i_modulus        (i_modulus),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_solution       (o_solution),
        .o_inverse        (o_inverse),
        .o_common_divisor (o_common_divisor)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Extended Euclid with signed Bezout terms, inverse folded into 0..m-1
    function automatic t_solution solve_congruence(input logic [WIDTH-1:0] a,
                                                   input logic [WIDTH-1:0] b,
                                                   input logic [WIDTH-1:0] m);
        longint    r_old, r_new, s_old, s_new, quo, tmp, mod_l, inv;
        t_solution res;
        res.solution = '0;
        res.inverse  = '0;
        if (m == '0) begin
            res.status         = ST_ZERO_MOD;
            res.common_divisor = a;
            return res;
        end
        mod_l = longint'(m);
        r_old = longint'(a);
        r_new = longint'(m);
        s_old = 1;
        s_new = 0;
        while (r_new != 0) begin
            quo   = r_old / r_new;
            tmp   = r_old - quo * r_new;
            r_old = r_new;
            r_new = tmp;
            tmp   = s_old - quo * s_new;
            s_old = s_new;
            s_new = tmp;
        end
        res.common_divisor = r_old[WIDTH-1:0];
        if (r_old != 1) begin
            res.status = ST_NO_INVERSE;
            return res;
        end
        inv = s_old % mod_l;
        if (inv < 0) inv += mod_l;
        res.status   = ST_SOLVED;
        res.inverse  = inv[WIDTH-1:0];
        tmp          = (inv * (longint'(b) % mod_l)) % mod_l;
        res.solution = tmp[WIDTH-1:0];
        return res;
    endfunction

    function automatic logic [WIDTH-1:0] rand_word();
        logic [31:0] w;
        w = $urandom();
        return w[WIDTH-1:0];
    endfunction

    task automatic add_congruence(input logic [WIDTH-1:0] a, input logic [WIDTH-1:0] b,
                                  input logic [WIDTH-1:0] m);
        t_congruence c;
        c.coefficient = a;
        c.rhs_value   = b;
        c.modulus     = m;
        congruence_queue.push_back(c);
    endtask

    task automatic check_field(input string name, input logic [WIDTH-1:0] exp_val,
                               input logic [WIDTH-1:0] act_val);
        if (exp_val !== act_val) begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_val, act_val);
        end
    endtask

    // Sender: idle with a chance of 29 in 100, except for offered items 500 to 699, where it never idles
    function automatic bit sender_idle();
        if (n_offered >= 500 && n_offered < 700) return 1'b0;
        return $urandom_range(99) < 29;
    endfunction

    // Driver: record accepted transfers, hold an offered item, offer the next
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                pending_solutions.push_back(
                    solve_congruence(i_coefficient, i_rhs_value, i_modulus));
                case (pending_solutions[$].status)
                    ST_SOLVED:     n_solved++;
                    ST_NO_INVERSE: n_no_inverse++;
                    default:       n_zero_mod++;
                endcase
            end
            if (start && busy) begin
                start <= 1'b1;
            end else if (congruence_queue.size() > 0 && !sender_idle()) begin
                next_congruence = congruence_queue.pop_front();
                n_offered++;
                start         <= 1'b1;
                i_coefficient <= next_congruence.coefficient;
                i_rhs_value   <= next_congruence.rhs_value;
                i_modulus     <= next_congruence.modulus;
            end else begin
                start         <= 1'b0;
                i_coefficient <= rand_word();
                i_rhs_value   <= rand_word();
                i_modulus     <= rand_word();
            end
        end
    end

    // Monitor: compare each result strobe against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_solutions.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with no transfer pending, status %0d", $time, o_status);
            end else begin
                check_field("status", WIDTH'(pending_solutions[0].status), WIDTH'(o_status));
                check_field("solution", pending_solutions[0].solution, o_solution);
                check_field("inverse", pending_solutions[0].inverse, o_inverse);
                check_field("common_divisor", pending_solutions[0].common_divisor,
                            o_common_divisor);
                void'(pending_solutions.pop_front());
                n_checked++;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_MAX) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_MAX);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        logic [WIDTH-1:0] a, b, m, d;
        int               sel;

        // Directed: zero modulus, modulus one, zero coefficient, field extremes
        add_congruence('0, '0, '0);
        add_congruence(MAX_VAL, MAX_VAL, '0);
        add_congruence(31'd12345, 31'd7, '0);
        add_congruence(MAX_VAL, MAX_VAL, 31'd1);
        add_congruence('0, '0, 31'd1);
        add_congruence('0, 31'd5, 31'd7);
        add_congruence('0, MAX_VAL, MAX_VAL);
        add_congruence(31'd1, MAX_VAL, MAX_VAL);
        add_congruence(MAX_VAL, MAX_VAL, MAX_VAL);
        add_congruence(MAX_VAL, MAX_VAL, MAX_VAL - 31'd1);
        add_congruence(MAX_VAL - 31'd1, MAX_VAL - 31'd1, MAX_VAL);
        add_congruence(31'd2, 31'd3, 31'd4);
        add_congruence(31'd3, 31'd5, 31'd7);
        add_congruence(31'd100, 31'd1000, 31'd7);
        add_congruence(31'd1, 31'd1, 31'd2);
        add_congruence(31'd1134903170, MAX_VAL, 31'd1836311903);
        add_congruence(31'd1836311903, 31'd1, 31'd1134903170);
        add_congruence(31'h55555555, 31'h2AAAAAAA, MAX_VAL);
        add_congruence(31'h2AAAAAAA, 31'h55555555, 31'h55555555);
        add_congruence(31'd6, 31'd4, 31'd9);
        add_congruence(31'h40000000, '0, 31'h40000001);

        // Random: mostly small moduli to keep the run short, full width for bit coverage
        repeat (N_RANDOM) begin
            sel = $urandom_range(99);
            b   = rand_word();
            if (sel < 30) begin
                a = rand_word();
                m = rand_word();
            end else if (sel < 70) begin
                a = WIDTH'($urandom_range(2000));
                m = WIDTH'($urandom_range(1, 1000));
            end else if (sel < 80) begin
                a = rand_word();
                m = MAX_VAL;
            end else if (sel < 90) begin
                // build a shared factor
                d = WIDTH'($urandom_range(2, 50));
                a = WIDTH'(d * $urandom_range(0, 1000));
                m = WIDTH'(d * $urandom_range(1, 1000));
            end else begin
                case ($urandom_range(3))
                    0: begin a = rand_word(); m = '0; end
                    1: begin a = rand_word(); m = 31'd1; end
                    2: begin a = '0; m = WIDTH'($urandom_range(2, 100000)); end
                    default: begin a = rand_word(); m = a; end
                endcase
            end
            add_congruence(a, b, m);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all offered, all accepted, all results back, then settle
        while (congruence_queue.size() > 0 || start) @(posedge i_clk);
        while (pending_solutions.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("Checked %0d results: %0d solved, %0d without inverse, %0d zero modulus",
                 n_checked, n_solved, n_no_inverse, n_zero_mod);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* files.f */
design/lcs_pkg.sv
design/lcs_div.sv
design/lcs_mulmod.sv
design/lcs_dp.sv
design/lcs_ctrl.sv
design/linear_congruence_solver_core.sv
dv/tb_linear_congruence_solver_core.sv
